[design/u16550_pkg.sv]
package u16550_pkg;

  localparam int RxDepthDefault  = 256;
  localparam int TxDepthDefault  = 256;
  localparam int DivisorDefault  = 1;

  localparam logic [3:0] REG_RBR = 4'd0;
  localparam logic [3:0] REG_THR = 4'd0;
  localparam logic [3:0] REG_DLL = 4'd0;
  localparam logic [3:0] REG_IER = 4'd1;
  localparam logic [3:0] REG_DLM = 4'd1;
  localparam logic [3:0] REG_IIR = 4'd2;
  localparam logic [3:0] REG_FCR = 4'd2;
  localparam logic [3:0] REG_LCR = 4'd3;
  localparam logic [3:0] REG_MCR = 4'd4;
  localparam logic [3:0] REG_LSR = 4'd5;
  localparam logic [3:0] REG_MSR = 4'd6;
  localparam logic [3:0] REG_SCR = 4'd7;

  localparam logic [3:0] IIR_NONE = 4'h1;
  localparam logic [3:0] IIR_LS   = 4'h6;
  localparam logic [3:0] IIR_RX   = 4'h4;
  localparam logic [3:0] IIR_TX   = 4'h2;
  localparam logic [3:0] IIR_MS   = 4'h0;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_PUSH  = 2'd2,
    OP_POP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    SRC_REG = 2'd0,
    SRC_RX  = 2'd1,
    SRC_TX  = 2'd2
  } src_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic       clear;
    logic [7:0] data;
  } fifo_cmd_t;

endpackage

[design/uart16550_register_model.sv]
// register file of a 16550-style uart with receive and transmit fifos
// input channel: in_valid / in_stall with opcode, offset and wr_data;
//   opcode 0 bus read, 1 bus write, 2 host pushes a received byte,
//   3 host pops a transmit byte
// output channel: out_valid / out_stall with read_data and irq, one item
//   out for every item in, in the same order
// out_valid rises when an item leaves the memory read stage for the output register:
//   register state and fifo pointers update at the accepting edge, the fifo
//   memories deliver popped bytes through their registered read port, and an
//   output register follows
// throughput is one item per cycle when not stalled; register and fifo state
//   are updated in place so the next item sees the previous result at once
// while out_stall is high the output holds, one more item is taken into the
//   memory read stage, and then in_stall rises until the output drains
// reset clears all control registers, empties both fifos, loads the divisor
//   latches from DIVISOR_RESET and marks the transmitter empty; no clearing
//   pass runs, items are taken in the first cycle after reset
module uart16550_register_model import u16550_pkg::*; #(
  parameter int RX_DEPTH      = RxDepthDefault,
  parameter int TX_DEPTH      = TxDepthDefault,
  parameter int DIVISOR_RESET = DivisorDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] opcode,
  input  logic [3:0] offset,
  input  logic [7:0] wr_data,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] read_data,
  output logic       irq
);

  fifo_cmd_t  rx_cmd;
  fifo_cmd_t  tx_cmd;
  logic       rx_empty;
  logic       tx_empty;
  logic [7:0] rx_rdata;
  logic [7:0] tx_rdata;
  logic [7:0] reg_rdata;
  src_t       src;
  logic       irq_next;

  logic       accept;
  logic       out_free;
  logic       s1_adv;
  logic       s1_valid;
  src_t       s1_src;
  logic       s1_empty;
  logic [7:0] s1_data;
  logic       s1_irq;
  logic [7:0] s1_result;

  assign out_free = !out_valid || !out_stall;
  assign s1_adv   = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;
  assign accept   = in_valid && !in_stall;

  u16550_regs #(
    .DIVISOR_RESET(DIVISOR_RESET)
  ) u_regs (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .opcode   (opcode),
    .offset   (offset),
    .wr_data  (wr_data),
    .rx_empty (rx_empty),
    .rx_cmd   (rx_cmd),
    .tx_cmd   (tx_cmd),
    .reg_rdata(reg_rdata),
    .src      (src),
    .irq_next (irq_next)
  );

  u16550_fifo #(
    .DEPTH(RX_DEPTH)
  ) u_rx_fifo (
    .clk  (clk),
    .rst  (rst),
    .cmd  (rx_cmd),
    .empty(rx_empty),
    .rdata(rx_rdata)
  );

  u16550_fifo #(
    .DEPTH(TX_DEPTH)
  ) u_tx_fifo (
    .clk  (clk),
    .rst  (rst),
    .cmd  (tx_cmd),
    .empty(tx_empty),
    .rdata(tx_rdata)
  );

  // empty pops read as all ones
  always_comb begin
    case (s1_src)
      SRC_RX:  s1_result = s1_empty ? 8'hFF : rx_rdata;
      SRC_TX:  s1_result = s1_empty ? 8'hFF : tx_rdata;
      default: s1_result = s1_data;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_src   <= src;
      s1_empty <= (src == SRC_RX) ? rx_empty : tx_empty;
      s1_data  <= reg_rdata;
      s1_irq   <= irq_next;
    end
    if (s1_adv) begin
      read_data <= s1_result;
      irq       <= s1_irq;
    end
  end

endmodule

[design/u16550_fifo.sv]
module u16550_fifo import u16550_pkg::*; #(
  parameter int DEPTH = RxDepthDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  fifo_cmd_t  cmd,
  output logic       empty,
  output logic [7:0] rdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [7:0]    mem [DEPTH];
  logic [AW-1:0] rd_ptr;
  logic [AW-1:0] wr_ptr;
  logic [CW-1:0] count;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    wrap_inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  assign empty = (count == '0);

  // entry storage and registered read port
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[wr_ptr] <= cmd.data;
    end
    if (cmd.pop) begin
      rdata <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else if (cmd.clear) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else if (cmd.push) begin
      wr_ptr <= wrap_inc(wr_ptr);
      if (count == CW'(DEPTH)) begin
        rd_ptr <= wrap_inc(rd_ptr);
      end else begin
        count <= count + CW'(1);
      end
    end else if (cmd.pop) begin
      if (!empty) begin
        rd_ptr <= wrap_inc(rd_ptr);
        count  <= count - CW'(1);
      end
    end
  end

endmodule

[design/u16550_regs.sv]
module u16550_regs import u16550_pkg::*; #(
  parameter int DIVISOR_RESET = DivisorDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [1:0] opcode,
  input  logic [3:0] offset,
  input  logic [7:0] wr_data,
  input  logic       rx_empty,
  output fifo_cmd_t  rx_cmd,
  output fifo_cmd_t  tx_cmd,
  output logic [7:0] reg_rdata,
  output src_t       src,
  output logic       irq_next
);

  localparam logic [15:0] DivReset = 16'(DIVISOR_RESET);

  localparam logic [7:0] LSR_DR        = 8'h01;
  localparam logic [7:0] LSR_OE        = 8'h02;
  localparam logic [7:0] LSR_ERR       = 8'h1E;
  localparam logic [7:0] LSR_THR_EMPTY = 8'h20;
  localparam logic [7:0] LSR_TX_IDLE   = 8'h40;
  localparam logic [7:0] MSR_DELTA     = 8'h0F;
  localparam logic [7:0] FCR_KEEP      = 8'hC9;

  logic [3:0] ier, ier_next;
  logic [7:0] lcr, lcr_next;
  logic [4:0] mcr, mcr_next;
  logic [7:0] fcr, fcr_next;
  logic [7:0] lsr, lsr_next;
  logic [7:0] msr, msr_next;
  logic [7:0] scr, scr_next;
  logic [7:0] dll, dll_next;
  logic [7:0] dlm, dlm_next;
  logic       thre, thre_next;

  logic [3:0] rsn;
  logic [7:0] lines;
  logic [7:0] diff;
  logic [7:0] lsr_rd;
  logic       dlab;

  function automatic logic [3:0] reason_f(input logic [7:0] ls, input logic [3:0] ie,
                                          input logic th, input logic [7:0] ms);
    if (|(ls & LSR_ERR) && ie[2]) begin
      reason_f = IIR_LS;
    end else if (ls[0] && ie[0]) begin
      reason_f = IIR_RX;
    end else if (th && ie[1]) begin
      reason_f = IIR_TX;
    end else if (|(ms & MSR_DELTA) && ie[3]) begin
      reason_f = IIR_MS;
    end else begin
      reason_f = IIR_NONE;
    end
  endfunction

  assign dlab = lcr[7];
  assign rsn  = reason_f(lsr, ier, thre, msr);

  always_comb begin
    ier_next  = ier;
    lcr_next  = lcr;
    mcr_next  = mcr;
    fcr_next  = fcr;
    lsr_next  = lsr;
    msr_next  = msr;
    scr_next  = scr;
    dll_next  = dll;
    dlm_next  = dlm;
    thre_next = thre;
    rx_cmd    = '0;
    tx_cmd    = '0;
    reg_rdata = '0;
    src       = SRC_REG;
    lines     = '0;
    diff      = '0;
    lsr_rd    = '0;
    if (accept) begin
      case (op_t'(opcode))
        OP_READ: begin
          if (dlab) begin
            if (offset == REG_DLL) begin
              reg_rdata = dll;
            end else if (offset == REG_DLM) begin
              reg_rdata = dlm;
            end
          end else begin
            case (offset)
              REG_RBR: begin
                lsr_next   = lsr & ~LSR_OE;
                rx_cmd.pop = 1'b1;
                src        = SRC_RX;
              end
              REG_IER: reg_rdata = {4'b0000, ier};
              REG_IIR: begin
                if (rsn == IIR_TX) begin
                  thre_next = 1'b0;
                end
                reg_rdata = {fcr[0], fcr[0], 2'b00, rsn};
              end
              REG_LCR: reg_rdata = lcr;
              REG_MCR: reg_rdata = {3'b000, mcr};
              REG_LSR: begin
                lsr_rd    = lsr | LSR_TX_IDLE | LSR_THR_EMPTY;
                lsr_rd    = rx_empty ? (lsr_rd & ~LSR_DR) : (lsr_rd | LSR_DR);
                reg_rdata = lsr_rd;
                lsr_next  = lsr_rd & ~LSR_OE;
              end
              REG_MSR: begin
                reg_rdata = msr;
                msr_next  = msr & ~MSR_DELTA;
              end
              REG_SCR: reg_rdata = scr;
              default: reg_rdata = 8'hFF;
            endcase
          end
        end
        OP_WRITE: begin
          if (dlab && offset == REG_DLL) begin
            dll_next = wr_data;
          end else if (dlab && offset == REG_DLM) begin
            dlm_next = wr_data;
          end else begin
            case (offset)
              REG_THR: begin
                if (mcr[4]) begin
                  rx_cmd.push = 1'b1;
                  rx_cmd.data = wr_data;
                  lsr_next    = lsr | LSR_OE;
                end else begin
                  tx_cmd.push = 1'b1;
                  tx_cmd.data = wr_data;
                end
                thre_next = 1'b1;
              end
              REG_IER: begin
                if (!ier[1] && wr_data[1]) begin
                  thre_next = 1'b1;
                end
                ier_next = wr_data[3:0];
              end
              REG_FCR: begin
                if (!wr_data[0]) begin
                  fcr_next = '0;
                end else begin
                  rx_cmd.clear = wr_data[1];
                  fcr_next     = wr_data & FCR_KEEP;
                end
              end
              REG_LCR: lcr_next = wr_data;
              REG_MCR: begin
                mcr_next = wr_data[4:0];
                if (wr_data[4]) begin
                  lines = {wr_data[3], wr_data[2], wr_data[0], wr_data[1], 4'b0000};
                end else begin
                  lines = 8'hA0;
                end
                diff     = lines ^ msr;
                msr_next = {lines[7:4], msr[3] | diff[7], msr[2] | (!lines[6] && msr[6]),
                            msr[1] | diff[5], msr[0] | diff[4]};
              end
              REG_SCR: scr_next = wr_data;
              default: ;
            endcase
          end
        end
        OP_PUSH: begin
          rx_cmd.push = 1'b1;
          rx_cmd.data = wr_data;
          lsr_next    = lsr | LSR_DR;
        end
        default: begin
          tx_cmd.pop = 1'b1;
          src        = SRC_TX;
        end
      endcase
    end
    irq_next = (reason_f(lsr_next, ier_next, thre_next, msr_next) != IIR_NONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ier  <= '0;
      lcr  <= '0;
      mcr  <= '0;
      fcr  <= '0;
      lsr  <= '0;
      msr  <= '0;
      scr  <= '0;
      dll  <= DivReset[7:0];
      dlm  <= DivReset[15:8];
      thre <= 1'b1;
    end else begin
      ier  <= ier_next;
      lcr  <= lcr_next;
      mcr  <= mcr_next;
      fcr  <= fcr_next;
      lsr  <= lsr_next;
      msr  <= msr_next;
      scr  <= scr_next;
      dll  <= dll_next;
      dlm  <= dlm_next;
      thre <= thre_next;
    end
  end

endmodule
